@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL; clock is clk, reset is rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AST_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define AST_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/fba_pkg.sv @@
package fba_pkg;

  // One block table entry as stored in memory
  typedef struct packed {
    logic        free;
    logic [14:0] size;
    logic [15:0] addr;
  } entry_t;

  localparam int ENTRY_W = 32;

  // Largest block size in words
  localparam logic [14:0] SIZE_MAX = 15'h7fff;

  // Request modes
  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;
  localparam logic [1:0] MODE_INIT  = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_UNKNOWN  = 2'd2;
  localparam logic [1:0] ST_IS_FREE  = 2'd3;

endpackage

@@ rtl/fba_ram.sv @@
module fba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/first_fit_block_allocator_unit.sv @@
// Channel   | Signals                                          | Handshake
// ----------+--------------------------------------------------+------------------------------
// request   | mode, item_count, type_length, block_address     | start && !busy
// result    | status, result_address, result_size              | done, one cycle, no stall
// config    | chunk_limit                                      | cfg_valid && cfg_ready
//
// One request at a time. Allocate or init appends when the block fits under capacity, else
// takes the first free entry that fits, shifting entries up on a split, else grows capacity
// by chunks and appends. Free and query search the table by address; free merges with free
// neighbours and shifts entries down to close the gap. Table entries are read one at a time.
// Synchronous reset clears counters and marks; the table needs no clearing pass.
// The result receiver cannot stall; busy falls in the cycle done is shown.
// Configuration is taken only while idle. CHUNK_WORDS must be a power of two.
`include "assert_macros.svh"

module first_fit_block_allocator_unit #(
  parameter int MAX_BLOCKS      = 64,
  parameter int CHUNK_WORDS     = 256,
  parameter int MAX_CHUNK_COUNT = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [14:0] item_count,
  input  logic [7:0]  type_length,
  input  logic [15:0] block_address,
  output logic        done,
  output logic [1:0]  status,
  output logic [15:0] result_address,
  output logic [14:0] result_size,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  chunk_limit
);

  localparam int IW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW  = $clog2(MAX_BLOCKS + 1);
  localparam int CLG = $clog2(CHUNK_WORDS);
  localparam logic [CW-1:0] MAX_N = CW'(MAX_BLOCKS);
  localparam logic [17:0] MCC = 18'(MAX_CHUNK_COUNT);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_PREP     = 5'd1;
  localparam logic [4:0] S_APPEND   = 5'd2;
  localparam logic [4:0] S_SCAN_RD  = 5'd3;
  localparam logic [4:0] S_SCAN_CHK = 5'd4;
  localparam logic [4:0] S_UP_RD    = 5'd5;
  localparam logic [4:0] S_UP_WR    = 5'd6;
  localparam logic [4:0] S_SPLIT_HI = 5'd7;
  localparam logic [4:0] S_SPLIT_LO = 5'd8;
  localparam logic [4:0] S_GROW     = 5'd9;
  localparam logic [4:0] S_GROW2    = 5'd10;
  localparam logic [4:0] S_FIND_RD  = 5'd11;
  localparam logic [4:0] S_FIND_CHK = 5'd12;
  localparam logic [4:0] S_NEXT_RD  = 5'd13;
  localparam logic [4:0] S_NEXT_CHK = 5'd14;
  localparam logic [4:0] S_MERGE    = 5'd15;
  localparam logic [4:0] S_DN_RD    = 5'd16;
  localparam logic [4:0] S_DN_WR    = 5'd17;

  logic [4:0]  state;
  logic [1:0]  op_mode;
  logic [14:0] req_count;
  logic [7:0]  req_tlen;
  logic [15:0] req_addr;
  logic [14:0] req_size;
  logic [CW-1:0] block_count;
  logic [15:0] end_mark;
  logic [15:0] capacity;
  logic [6:0]  cfg_limit;
  logic [CW-1:0] idx;
  logic [CW-1:0] shift_idx;
  logic [CW-1:0] hit_idx;
  logic [1:0]  erase_n;
  logic [16:0] need;
  logic        next_ok;
  fba_pkg::entry_t cur_entry;
  fba_pkg::entry_t prev_entry;
  fba_pkg::entry_t next_entry;

  logic        ram_we;
  logic [IW-1:0] ram_waddr;
  logic [IW-1:0] ram_raddr;
  fba_pkg::entry_t ram_wdata;
  fba_pkg::entry_t ram_rdata;

  // Request size and placement checks
  logic [22:0] prod;
  logic        fits_above;
  logic        table_full;
  logic [15:0] dsize;
  logic [16:0] need_calc;
  logic [17:0] chunk_sum;
  logic [17:0] limit_eff;
  logic [32:0] new_cap;
  logic        scan_hit;

  // Merge arithmetic
  logic        merge_prev;
  logic        merge_next;
  logic [15:0] sum_prev;
  logic [14:0] msize;
  logic [15:0] maddr;
  logic [15:0] sum_next;
  logic [14:0] fsize;
  logic [CW-1:0] win_idx;
  logic [1:0]  erase_calc;
  logic [CW-1:0] dn_src;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  always_comb begin
    if (op_mode == fba_pkg::MODE_INIT) begin
      prod = {8'd0, req_count};
    end else begin
      prod = {8'd0, req_count} * {15'd0, req_tlen};
    end
    fits_above = ({2'b0, req_size} + {1'b0, end_mark}) <= {1'b0, capacity};
    table_full = (block_count >= MAX_N);
    dsize      = {1'b0, req_size} - (capacity - end_mark);
    need_calc  = ({1'b0, dsize} + 17'(CHUNK_WORDS - 1)) >> CLG;
    chunk_sum  = 18'(capacity >> CLG) + {1'b0, need};
    limit_eff  = ({11'd0, cfg_limit} < MCC) ? {11'd0, cfg_limit} : MCC;
    new_cap    = {17'd0, capacity} + ({16'd0, need} << CLG);
    scan_hit   = ram_rdata.free && (ram_rdata.size >= req_size);

    merge_prev = (hit_idx != '0) && prev_entry.free;
    sum_prev   = {1'b0, prev_entry.size} + {1'b0, cur_entry.size};
    merge_prev = merge_prev && (sum_prev <= {1'b0, fba_pkg::SIZE_MAX});
    msize      = merge_prev ? sum_prev[14:0] : cur_entry.size;
    maddr      = merge_prev ? prev_entry.addr : cur_entry.addr;
    sum_next   = {1'b0, next_entry.size} + {1'b0, msize};
    merge_next = next_ok && next_entry.free && (sum_next <= {1'b0, fba_pkg::SIZE_MAX});
    fsize      = merge_next ? sum_next[14:0] : msize;
    win_idx    = merge_prev ? hit_idx - CW'(1) : hit_idx;
    erase_calc = {1'b0, merge_prev} + {1'b0, merge_next};
    dn_src     = shift_idx + {{(CW-2){1'b0}}, erase_n};
  end

  // Memory port control per state
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = ram_rdata;
    ram_raddr = '0;
    case (state)
      S_APPEND: begin
        ram_we    = 1'b1;
        ram_waddr = block_count[IW-1:0];
        ram_wdata = '{free: 1'b0, size: req_size, addr: end_mark};
      end
      S_SCAN_RD: ram_raddr = idx[IW-1:0];
      S_SCAN_CHK: begin
        ram_we    = scan_hit && (ram_rdata.size == req_size);
        ram_waddr = idx[IW-1:0];
        ram_wdata = '{free: 1'b0, size: req_size, addr: ram_rdata.addr};
      end
      S_UP_RD: ram_raddr = IW'(shift_idx - CW'(1));
      S_UP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = shift_idx[IW-1:0];
      end
      S_SPLIT_HI: begin
        ram_we    = 1'b1;
        ram_waddr = IW'(hit_idx + CW'(1));
        ram_wdata = '{free: 1'b1, size: cur_entry.size - req_size,
                      addr: cur_entry.addr + {1'b0, req_size}};
      end
      S_SPLIT_LO: begin
        ram_we    = 1'b1;
        ram_waddr = hit_idx[IW-1:0];
        ram_wdata = '{free: 1'b0, size: req_size, addr: cur_entry.addr};
      end
      S_FIND_RD: ram_raddr = idx[IW-1:0];
      S_NEXT_RD: ram_raddr = IW'(hit_idx + CW'(1));
      S_MERGE: begin
        ram_we    = 1'b1;
        ram_waddr = win_idx[IW-1:0];
        ram_wdata = '{free: 1'b1, size: fsize, addr: maddr};
      end
      S_DN_RD: ram_raddr = dn_src[IW-1:0];
      S_DN_WR: begin
        ram_we    = 1'b1;
        ram_waddr = shift_idx[IW-1:0];
      end
      default: ;
    endcase
  end

  fba_ram #(
    .WIDTH(fba_pkg::ENTRY_W),
    .DEPTH(MAX_BLOCKS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_limit <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      cfg_limit <= chunk_limit;
    end
  end

  // Request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      block_count <= '0;
      end_mark    <= '0;
      capacity    <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op_mode   <= mode;
            req_count <= item_count;
            req_tlen  <= type_length;
            req_addr  <= block_address;
            idx       <= '0;
            if (mode == fba_pkg::MODE_INIT) begin
              block_count <= '0;
              end_mark    <= '0;
              capacity    <= '0;
            end
            if (mode == fba_pkg::MODE_FREE || mode == fba_pkg::MODE_QUERY) begin
              state <= S_FIND_RD;
            end else begin
              state <= S_PREP;
            end
          end
        end
        S_PREP: begin
          req_size <= prod[14:0];
          if (prod > {8'd0, fba_pkg::SIZE_MAX}) begin
            state <= S_IDLE;
            done  <= 1'b1;
            status <= fba_pkg::ST_NO_SPACE;
            result_address <= '0;
            result_size    <= '0;
          end else begin
            state <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: begin
          // First pass decides between append and scan
          if (idx == '0 && fits_above) begin
            if (table_full) begin
              state <= S_IDLE;
              done  <= 1'b1;
              status <= fba_pkg::ST_NO_SPACE;
              result_address <= '0;
              result_size    <= '0;
            end else begin
              state <= S_APPEND;
            end
          end else if (idx == block_count) begin
            state <= S_GROW;
          end else begin
            state <= S_SCAN_CHK;
          end
        end
        S_SCAN_CHK: begin
          if (scan_hit) begin
            cur_entry <= ram_rdata;
            hit_idx   <= idx;
            shift_idx <= block_count;
            if (ram_rdata.size == req_size) begin
              state <= S_IDLE;
              done  <= 1'b1;
              status <= fba_pkg::ST_OK;
              result_address <= ram_rdata.addr;
              result_size    <= req_size;
            end else if (table_full) begin
              state <= S_IDLE;
              done  <= 1'b1;
              status <= fba_pkg::ST_NO_SPACE;
              result_address <= '0;
              result_size    <= '0;
            end else begin
              state <= S_UP_RD;
            end
          end else begin
            idx   <= idx + CW'(1);
            state <= S_SCAN_RD;
          end
        end
        S_UP_RD: begin
          if (shift_idx == hit_idx + CW'(1)) begin
            state <= S_SPLIT_HI;
          end else begin
            state <= S_UP_WR;
          end
        end
        S_UP_WR: begin
          shift_idx <= shift_idx - CW'(1);
          state     <= S_UP_RD;
        end
        S_SPLIT_HI: state <= S_SPLIT_LO;
        S_SPLIT_LO: begin
          block_count <= block_count + CW'(1);
          state  <= S_IDLE;
          done   <= 1'b1;
          status <= fba_pkg::ST_OK;
          result_address <= cur_entry.addr;
          result_size    <= req_size;
        end
        S_GROW: begin
          need <= need_calc;
          if (table_full) begin
            state <= S_IDLE;
            done  <= 1'b1;
            status <= fba_pkg::ST_NO_SPACE;
            result_address <= '0;
            result_size    <= '0;
          end else begin
            state <= S_GROW2;
          end
        end
        S_GROW2: begin
          if (chunk_sum > limit_eff || new_cap > 33'h0ffff) begin
            state <= S_IDLE;
            done  <= 1'b1;
            status <= fba_pkg::ST_NO_SPACE;
            result_address <= '0;
            result_size    <= '0;
          end else begin
            capacity <= new_cap[15:0];
            state    <= S_APPEND;
          end
        end
        S_APPEND: begin
          block_count <= block_count + CW'(1);
          end_mark    <= end_mark + {1'b0, req_size};
          state  <= S_IDLE;
          done   <= 1'b1;
          status <= fba_pkg::ST_OK;
          result_address <= end_mark;
          result_size    <= req_size;
        end
        S_FIND_RD: begin
          if (idx == block_count) begin
            state <= S_IDLE;
            done  <= 1'b1;
            status <= fba_pkg::ST_UNKNOWN;
            result_address <= '0;
            result_size    <= '0;
          end else begin
            state <= S_FIND_CHK;
          end
        end
        S_FIND_CHK: begin
          if (ram_rdata.addr == req_addr) begin
            cur_entry <= ram_rdata;
            hit_idx   <= idx;
            result_address <= '0;
            if (ram_rdata.free) begin
              state <= S_IDLE;
              done  <= 1'b1;
              status <= fba_pkg::ST_IS_FREE;
              result_size <= '0;
            end else if (op_mode == fba_pkg::MODE_QUERY) begin
              state <= S_IDLE;
              done  <= 1'b1;
              status <= fba_pkg::ST_OK;
              result_size <= ram_rdata.size;
            end else begin
              state <= S_NEXT_RD;
            end
          end else begin
            prev_entry <= ram_rdata;
            idx   <= idx + CW'(1);
            state <= S_FIND_RD;
          end
        end
        S_NEXT_RD: begin
          next_ok <= (hit_idx + CW'(1)) < block_count;
          state   <= S_NEXT_CHK;
        end
        S_NEXT_CHK: begin
          next_entry <= ram_rdata;
          state      <= S_MERGE;
        end
        S_MERGE: begin
          // Write merged entry, then close the gap left behind
          erase_n   <= erase_calc;
          shift_idx <= win_idx + CW'(1);
          if (erase_calc == 2'd0) begin
            state  <= S_IDLE;
            done   <= 1'b1;
            status <= fba_pkg::ST_OK;
            result_size <= cur_entry.size;
          end else begin
            state <= S_DN_RD;
          end
        end
        S_DN_RD: begin
          if (dn_src >= block_count) begin
            block_count <= block_count - {{(CW-2){1'b0}}, erase_n};
            state  <= S_IDLE;
            done   <= 1'b1;
            status <= fba_pkg::ST_OK;
            result_size <= cur_entry.size;
          end else begin
            state <= S_DN_WR;
          end
        end
        S_DN_WR: begin
          shift_idx <= shift_idx + CW'(1);
          state     <= S_DN_RD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `AST_NOW(a_done_idle, done, !busy, "result shown while still busy")
  `AST_NOW(a_count_range, 1'b1, block_count <= MAX_N, "block count past table depth")
  `AST_NOW(a_end_in_cap, 1'b1, end_mark <= capacity, "end mark above capacity")
  `AST_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction not in progress")

endmodule

@@ dv/tb_first_fit_block_allocator_unit.sv @@
module tb_first_fit_block_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBLK   = 64;
  localparam int CHUNK  = 256;
  localparam int MAXCHK = 64;
  localparam int CYCLE_LIMIT = 2_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  mode = fba_pkg::MODE_QUERY;
  logic [14:0] item_count = '0;
  logic [7:0]  type_length = '0;
  logic [15:0] block_address = '0;
  logic        done;
  logic [1:0]  status;
  logic [15:0] result_address;
  logic [14:0] result_size;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  chunk_limit = 7'd64;

  typedef struct {
    logic [1:0]  st;
    logic [15:0] addr;
    logic [14:0] size;
  } alloc_result_t;

  alloc_result_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;

  // Shadow copy of the block table and allocator marks
  bit [15:0]   blk_addr[NBLK];
  bit [14:0]   blk_size[NBLK];
  bit          blk_free[NBLK];
  int unsigned blk_count = 0;
  int unsigned end_mark = 0;
  int unsigned capacity = 0;
  int unsigned limit_reg = 64;

  first_fit_block_allocator_unit u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .item_count(item_count), .type_length(type_length),
    .block_address(block_address), .done(done), .status(status),
    .result_address(result_address), .result_size(result_size),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .chunk_limit(chunk_limit)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Watchdog on total run length
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[first_fit_block_allocator_unit] ERROR");
      $finish;
    end
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // Append a block above the end mark
  function automatic bit append_block(input int unsigned size, output int unsigned a);
    if (blk_count >= NBLK) return 0;
    blk_addr[blk_count] = end_mark[15:0];
    blk_size[blk_count] = size[14:0];
    blk_free[blk_count] = 1'b0;
    blk_count++;
    a = end_mark;
    end_mark = (end_mark + size) & 16'hffff;
    return 1;
  endfunction

  // Place a block: append, else first fit with split, else grow by chunks
  function automatic bit reserve_words(input int unsigned size, output int unsigned a);
    int unsigned need, have, lim, newcap;
    a = 0;
    if (size + end_mark <= capacity) return append_block(size, a);
    for (int unsigned i = 0; i < blk_count; i++) begin
      if (blk_free[i] && blk_size[i] >= size) begin
        if (blk_size[i] > size) begin
          if (blk_count >= NBLK) return 0;
          for (int unsigned k = blk_count; k > i + 1; k--) begin
            blk_addr[k] = blk_addr[k-1];
            blk_size[k] = blk_size[k-1];
            blk_free[k] = blk_free[k-1];
          end
          blk_addr[i+1] = blk_addr[i] + size[15:0];
          blk_size[i+1] = blk_size[i] - size[14:0];
          blk_free[i+1] = 1'b1;
          blk_count++;
        end
        blk_size[i] = size[14:0];
        blk_free[i] = 1'b0;
        a = blk_addr[i];
        return 1;
      end
    end
    if (blk_count >= NBLK) return 0;
    need = (size - (capacity - end_mark) + CHUNK - 1) / CHUNK;
    have = capacity / CHUNK;
    lim = (limit_reg < MAXCHK) ? limit_reg : MAXCHK;
    if (have + need > lim) return 0;
    newcap = capacity + need * CHUNK;
    if (newcap > 16'hffff) return 0;
    capacity = newcap;
    return append_block(size, a);
  endfunction

  // Drop entry i, closing the gap
  function automatic void erase_entry(input int unsigned i);
    for (int unsigned k = i; k + 1 < blk_count; k++) begin
      blk_addr[k] = blk_addr[k+1];
      blk_size[k] = blk_size[k+1];
      blk_free[k] = blk_free[k+1];
    end
    blk_count--;
  endfunction

  function automatic alloc_result_t predict_request(input logic [1:0] m, input int unsigned cnt,
                                                    input int unsigned tlen,
                                                    input logic [15:0] baddr);
    alloc_result_t r;
    int unsigned size, a, i;
    int f;
    r.st = fba_pkg::ST_OK; r.addr = '0; r.size = '0;
    if (m == fba_pkg::MODE_ALLOC || m == fba_pkg::MODE_INIT) begin
      if (m == fba_pkg::MODE_INIT) begin
        blk_count = 0; end_mark = 0; capacity = 0;
        size = cnt;
      end else begin
        size = cnt * tlen;
      end
      if (size > fba_pkg::SIZE_MAX || !reserve_words(size, a)) r.st = fba_pkg::ST_NO_SPACE;
      else begin
        r.addr = a[15:0];
        r.size = size[14:0];
      end
      return r;
    end
    f = -1;
    for (int unsigned k = 0; k < blk_count; k++)
      if (f < 0 && blk_addr[k] == baddr) f = k;
    if (f < 0) r.st = fba_pkg::ST_UNKNOWN;
    else if (blk_free[f]) r.st = fba_pkg::ST_IS_FREE;
    else if (m == fba_pkg::MODE_QUERY) r.size = blk_size[f];
    else begin
      i = f;
      r.size = blk_size[i];
      // Merge with a free lower neighbor, then a free upper neighbor
      if (i > 0 && blk_free[i-1] &&
          int'(blk_size[i-1]) + int'(blk_size[i]) <= int'(fba_pkg::SIZE_MAX)) begin
        blk_size[i-1] = blk_size[i-1] + blk_size[i];
        erase_entry(i);
        i--;
      end
      if (i + 1 < blk_count && blk_free[i+1] &&
          int'(blk_size[i+1]) + int'(blk_size[i]) <= int'(fba_pkg::SIZE_MAX)) begin
        blk_size[i+1] = blk_size[i+1] + blk_size[i];
        blk_addr[i+1] = blk_addr[i];
        erase_entry(i);
      end
      blk_free[i] = 1'b1;
    end
    return r;
  endfunction

  // Send one request and record its expected outcome at acceptance
  task automatic send_request(input logic [1:0] m, input int unsigned cnt,
                              input int unsigned tlen, input logic [15:0] baddr);
    mode <= m;
    item_count <= cnt[14:0];
    type_length <= tlen[7:0];
    block_address <= baddr;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_request(m, cnt[14:0], tlen[7:0], baddr));
    if ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Hold off until every outstanding transaction has returned
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_chunk_limit(input int unsigned v);
    drain();
    chunk_limit <= v[6:0];
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    limit_reg = v & 7'h7f;
  endtask

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    alloc_result_t w;
    if (!rst && done) begin
      if (pending_results.size() == 0) report("unexpected result", status, -1);
      else begin
        w = pending_results.pop_front();
        if (status !== w.st) report("status", status, w.st);
        if (result_address !== w.addr) report("result_address", result_address, w.addr);
        if (result_size !== w.size) report("result_size", result_size, w.size);
      end
    end
  end

  function automatic logic [15:0] pick_live_address();
    if (blk_count == 0 || $urandom_range(9) == 0) return 16'($urandom);
    return blk_addr[$urandom_range(blk_count - 1)];
  endfunction

  task automatic test_alloc_extremes();
    send_request(fba_pkg::MODE_INIT, 0, 0, 16'd0);
    send_request(fba_pkg::MODE_ALLOC, 15'h7fff, 255, 16'hffff);
    send_request(fba_pkg::MODE_ALLOC, 129, 255, 16'd0);
    send_request(fba_pkg::MODE_ALLOC, 128, 2, 16'd0);
    send_request(fba_pkg::MODE_ALLOC, 0, 77, 16'd0);
    send_request(fba_pkg::MODE_ALLOC, 15'h7fff, 0, 16'd0);
    send_request(fba_pkg::MODE_ALLOC, 1, 1, 16'd0);
  endtask

  task automatic test_free_and_query();
    send_request(fba_pkg::MODE_QUERY, 0, 0, 16'd256);
    send_request(fba_pkg::MODE_FREE, 0, 0, 16'd0);
    send_request(fba_pkg::MODE_FREE, 0, 0, 16'd0);
    send_request(fba_pkg::MODE_QUERY, 0, 0, 16'd0);
    send_request(fba_pkg::MODE_QUERY, 0, 0, 16'hffff);
    send_request(fba_pkg::MODE_FREE, 0, 0, 16'd256);
    send_request(fba_pkg::MODE_ALLOC, 10, 3, 16'd0);
    send_request(fba_pkg::MODE_FREE, 0, 0, 16'd0);
  endtask

  task automatic test_growth_limit();
    send_request(fba_pkg::MODE_INIT, 15'h7fff, 0, 16'd0);
    write_chunk_limit(0);
    send_request(fba_pkg::MODE_INIT, 0, 0, 16'd0);
    send_request(fba_pkg::MODE_ALLOC, 5, 5, 16'd0);
    write_chunk_limit(127);
    send_request(fba_pkg::MODE_INIT, 16384, 0, 16'd0);
    send_request(fba_pkg::MODE_ALLOC, 1, 1, 16'd0);
    write_chunk_limit(1);
    send_request(fba_pkg::MODE_INIT, 256, 0, 16'd0);
    send_request(fba_pkg::MODE_ALLOC, 1, 1, 16'd0);
  endtask

  // Mostly live-table traffic with a share of noise and resets
  task automatic test_random(input int n);
    int r;
    for (int j = 0; j < n; j++) begin
      r = $urandom_range(99);
      if (r < 3) send_request(fba_pkg::MODE_INIT, $urandom_range(0, 600), $urandom,
                              16'($urandom));
      else if (r < 5) send_request(fba_pkg::MODE_INIT, $urandom, $urandom, 16'($urandom));
      else if (r < 45) send_request(fba_pkg::MODE_ALLOC, $urandom_range(0, 24),
                                    $urandom_range(0, 12), 16'($urandom));
      else if (r < 49) send_request(fba_pkg::MODE_ALLOC, $urandom, $urandom, 16'($urandom));
      else if (r < 77) send_request(fba_pkg::MODE_FREE, $urandom, $urandom,
                                    pick_live_address());
      else if (r < 92) send_request(fba_pkg::MODE_QUERY, $urandom, $urandom,
                                    pick_live_address());
      else send_request(2'($urandom_range(1, 2)), $urandom, $urandom, 16'($urandom));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_alloc_extremes();
    test_free_and_query();
    test_growth_limit();
    write_chunk_limit(64);
    send_idle_pct = 16;
    test_random(350);
    write_chunk_limit($urandom_range(2, 10));
    send_idle_pct = 66;
    test_random(350);
    write_chunk_limit(127);
    send_idle_pct = 0;
    test_random(350);
    drain();
    repeat (300) @(posedge clk);
    if (errors == 0) $display("[first_fit_block_allocator_unit] OK");
    else $display("[first_fit_block_allocator_unit] ERROR");
    $finish;
  end

endmodule
